@@ design/mas_pkg.sv @@
// Shared types, codes and helpers for the matrix add/subtract/multiply engine.
package mas_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DIM_CW      = 5;   // holds a dimension 1..16
  localparam int IDX_W       = 3;   // row/col field width
  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int ADDR_W      = 4;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_PROD = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;   // unused code, behaves as product

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;
  localparam logic [1:0] REG_COLS  = 2'd3;

  typedef struct packed {
    logic             vld;
    logic             err;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic             we_a;
    logic             we_b;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic              prod;
    logic              sub;
    logic [DIM_CW-1:0] ni;
  } ctl_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DIM_CW-1:0] ra;
    logic [DIM_CW-1:0] ni;
    logic [DIM_CW-1:0] cb;
  } cfg_t;

  // zero acts as one, oversize clamps to the array dimension
  function automatic logic [DIM_CW-1:0] eff_dim(input logic [3:0] v, input int maxd);
    logic [DIM_CW-1:0] r;
    if (v == 4'd0) r = DIM_CW'(1);
    else if (DIM_CW'(v) > DIM_CW'(maxd)) r = DIM_CW'(maxd);
    else r = DIM_CW'(v);
    return r;
  endfunction

endpackage

@@ design/mas_cfg.sv @@
// APB register file for mode and matrix dimensions.
module mas_cfg #(
  parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [mas_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output mas_pkg::cfg_t             cfg
);

  logic [1:0] mode_r;
  logic [3:0] rows_r, inner_r, cols_r;
  logic       wr_en;
  logic [1:0] ridx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign ridx       = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mas_pkg::MODE_PROD;
      rows_r  <= 4'd1;
      inner_r <= 4'd1;
      cols_r  <= 4'd1;
    end else if (wr_en) begin
      case (ridx)
        mas_pkg::REG_MODE:  mode_r  <= cfg_pwdata[1:0];
        mas_pkg::REG_ROWS:  rows_r  <= cfg_pwdata[3:0];
        mas_pkg::REG_INNER: inner_r <= cfg_pwdata[3:0];
        mas_pkg::REG_COLS:  cols_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mas_pkg::REG_MODE:  cfg_prdata = {30'd0, mode_r};
      mas_pkg::REG_ROWS:  cfg_prdata = {28'd0, rows_r};
      mas_pkg::REG_INNER: cfg_prdata = {28'd0, inner_r};
      mas_pkg::REG_COLS:  cfg_prdata = {28'd0, cols_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.mode = mode_r;
  assign cfg.ra   = mas_pkg::eff_dim(rows_r, MAX_DIM);
  assign cfg.ni   = mas_pkg::eff_dim(inner_r, MAX_DIM);
  assign cfg.cb   = mas_pkg::eff_dim(cols_r, MAX_DIM);

endmodule

@@ design/mas_cell.sv @@
// One chain cell: holds column IDX of A and row IDX of B, adds its term to the running sum.
module mas_cell #(
  parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF,
  parameter int IDX     = 0,
  parameter int ACC_W   = 69
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  mas_pkg::wr_t            wr,
  input  mas_pkg::ctl_t           ctl,
  input  mas_pkg::tag_t           tag_i,
  input  logic signed [ACC_W-1:0] sum_i,
  output mas_pkg::tag_t           tag_o,
  output logic signed [ACC_W-1:0] sum_o
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [mas_pkg::VAL_W-1:0] mem_a [MAX_DIM];
  logic [mas_pkg::VAL_W-1:0] mem_b [MAX_DIM];
  logic [MAX_DIM-1:0]        va_r, vb_r;
  logic                      hit_a, hit_b;
  logic [DIM_W-1:0]          wa_idx, wb_idx, ra_idx, rb_idx;

  // stage 1: element read
  mas_pkg::tag_t             tag1_r;
  logic signed [ACC_W-1:0]   sum1_r;
  logic [mas_pkg::VAL_W-1:0] a_rd_r, b_rd_r;
  logic                      a_ok_r, b_ok_r;
  // stage 2: term
  mas_pkg::tag_t             tag2_r;
  logic signed [ACC_W-1:0]   sum2_r;
  logic signed [63:0]        term_r, term_nxt;
  // stage 3: accumulate
  mas_pkg::tag_t             tag3_r;
  logic signed [ACC_W-1:0]   sum3_r;

  logic signed [31:0] a_s, b_s;
  logic signed [63:0] mul, ea, eb;
  logic               hit_r, hit_c, in_k;

  assign hit_a  = wr.we_a && (mas_pkg::DIM_CW'(wr.col) == mas_pkg::DIM_CW'(IDX));
  assign hit_b  = wr.we_b && (mas_pkg::DIM_CW'(wr.row) == mas_pkg::DIM_CW'(IDX));
  assign wa_idx = DIM_W'(wr.row);
  assign wb_idx = DIM_W'(wr.col);
  assign ra_idx = DIM_W'(tag_i.row);
  assign rb_idx = DIM_W'(tag_i.col);

  always_ff @(posedge clk) begin
    if (hit_a) mem_a[wa_idx] <= wr.data;
    if (hit_b) mem_b[wb_idx] <= wr.data;
    if (en) begin
      a_rd_r <= mem_a[ra_idx];
      b_rd_r <= mem_b[rb_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
      vb_r <= '0;
    end else begin
      if (hit_a) va_r[wa_idx] <= 1'b1;
      if (hit_b) vb_r[wb_idx] <= 1'b1;
    end
  end

  // unwritten entries read as zero
  assign a_s   = a_ok_r ? $signed(a_rd_r) : 32'sd0;
  assign b_s   = b_ok_r ? $signed(b_rd_r) : 32'sd0;
  assign mul   = a_s * b_s;
  assign hit_r = mas_pkg::DIM_CW'(tag1_r.row) == mas_pkg::DIM_CW'(IDX);
  assign hit_c = mas_pkg::DIM_CW'(tag1_r.col) == mas_pkg::DIM_CW'(IDX);
  assign in_k  = mas_pkg::DIM_CW'(IDX) < ctl.ni;
  // elementwise: A(r,c) lives in cell c, B(r,c) in cell r
  assign ea    = hit_c ? 64'(a_s) : 64'sd0;
  assign eb    = hit_r ? (ctl.sub ? -64'(b_s) : 64'(b_s)) : 64'sd0;

  always_comb begin
    if (tag1_r.err)    term_nxt = 64'sd0;
    else if (ctl.prod) term_nxt = in_k ? mul : 64'sd0;
    else               term_nxt = ea + eb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r <= sum_i;
      a_ok_r <= va_r[ra_idx];
      b_ok_r <= vb_r[rb_idx];
      sum2_r <= sum1_r;
      term_r <= term_nxt;
      sum3_r <= sum2_r + ACC_W'(term_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  assign tag_o = tag3_r;
  assign sum_o = sum3_r;

endmodule

@@ design/matrix_add_sub_multiply_top.sv @@
// Top level: load/compute sequencer, chain of MAC cells, saturating output register.
// Results: an in-range load emits nothing; an out-of-bounds load emits an error result.
//   Each result passes through three stages per cell, then the output register.
// Throughput: loads one per cycle when idle and no result is in flight; compute issues one
//   result per cycle unless the output stalls, and holds the input until all results have left.
// Reset (synchronous, rst_n low): element stores read zero, control and config registers return to defaults.
module matrix_add_sub_multiply_top #(
  parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [39:0]                in_tdata,   // row[2:0], col[5:3], value[37:6]
  input  logic [1:0]                 in_tuser,   // operation[1:0]
  // result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [39:0]                out_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6]
  output logic                       out_tuser,  // index_error
  output logic                       out_tlast,
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mas_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ACC_W = 65 + DIM_W;                     // sum of MAX_DIM 64-bit products
  localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COMP = 2'b10
  } st_t;

  mas_pkg::cfg_t cfg;

  mas_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  // input fields
  mas_pkg::op_t                 op;
  logic [mas_pkg::IDX_W-1:0]    in_row, in_col;
  logic [mas_pkg::VAL_W-1:0]    in_value;
  assign op       = mas_pkg::op_t'(in_tuser);
  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[37:6];

  logic prod, in_acc, en;
  assign prod   = cfg.mode[1];                 // mode 3 behaves as product
  assign in_acc = in_tvalid & in_tready;

  // whole chain advances unless the output register holds a result not yet taken
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;

  // load bounds follow the current mode
  logic [mas_pkg::DIM_CW-1:0] rlim, clim, oc;
  logic                       oob, is_load;
  always_comb begin
    if (op == mas_pkg::OP_LOAD_A || !prod) begin
      rlim = cfg.ra;
      clim = cfg.ni;
    end else begin
      rlim = cfg.ni;
      clim = cfg.cb;
    end
  end
  assign is_load = (op == mas_pkg::OP_LOAD_A) || (op == mas_pkg::OP_LOAD_B);
  assign oob     = (mas_pkg::DIM_CW'(in_row) >= rlim) || (mas_pkg::DIM_CW'(in_col) >= clim);
  assign oc      = prod ? cfg.cb : cfg.ni;

  mas_pkg::wr_t wr;
  assign wr.we_a = in_acc && op == mas_pkg::OP_LOAD_A && !oob;
  assign wr.we_b = in_acc && op == mas_pkg::OP_LOAD_B && !oob;
  assign wr.row  = in_row;
  assign wr.col  = in_col;
  assign wr.data = in_value;

  mas_pkg::ctl_t ctl;
  assign ctl.prod = prod;
  assign ctl.sub  = cfg.mode == mas_pkg::MODE_SUB;
  assign ctl.ni   = cfg.ni;

  // sequencer: walks the result in row-major order
  st_t                        st_r, st_nxt;
  logic [mas_pkg::DIM_CW-1:0] r_r, r_nxt, c_r, c_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       c_end, r_end;
  mas_pkg::tag_t              issue;

  assign c_end = (c_r + 1'b1) == oc;
  assign r_end = (r_r + 1'b1) == cfg.ra;

  always_comb begin
    st_nxt = st_r;
    r_nxt  = r_r;
    c_nxt  = c_r;
    issue  = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc && op == mas_pkg::OP_COMPUTE) begin
          st_nxt = ST_COMP;
          r_nxt  = '0;
          c_nxt  = '0;
        end else if (in_acc && is_load && oob) begin
          issue.vld  = 1'b1;
          issue.err  = 1'b1;
          issue.last = 1'b1;
          issue.row  = in_row;
          issue.col  = in_col;
        end
      end
      ST_COMP: begin
        if (en) begin
          issue.vld  = 1'b1;
          issue.last = c_end && r_end;
          issue.row  = mas_pkg::IDX_W'(r_r);
          issue.col  = mas_pkg::IDX_W'(c_r);
          if (c_end) begin
            c_nxt = '0;
            r_nxt = r_r + 1'b1;
            if (r_end) st_nxt = ST_IDLE;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // results in flight; an item is taken only with the chain empty
  always_comb begin
    cnt_nxt = cnt_r;
    if (issue.vld && en)          cnt_nxt = cnt_nxt + 1'b1;
    if (out_valid_r && out_tready) cnt_nxt = cnt_nxt - 1'b1;
  end

  assign in_tready = (st_r == ST_IDLE) && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    c_r <= c_nxt;
  end

  // cell chain
  mas_pkg::tag_t           ctag [MAX_DIM+1];
  logic signed [ACC_W-1:0] csum [MAX_DIM+1];
  assign ctag[0] = issue;
  assign csum[0] = '0;

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    mas_cell #(.MAX_DIM(MAX_DIM), .IDX(k), .ACC_W(ACC_W)) u_cell (
      .clk, .rst_n, .en, .wr, .ctl,
      .tag_i(ctag[k]), .sum_i(csum[k]),
      .tag_o(ctag[k+1]), .sum_o(csum[k+1])
    );
  end

  // product drops 16 fraction bits (floor), then both paths saturate to 32 bits
  mas_pkg::tag_t             ftag;
  logic signed [ACC_W-1:0]   q;
  logic                      fits;
  logic [mas_pkg::VAL_W-1:0] sat;
  assign ftag = ctag[MAX_DIM];
  assign q    = prod ? (csum[MAX_DIM] >>> mas_pkg::FRAC_W) : csum[MAX_DIM];
  assign fits = (q[ACC_W-1:31] == '0) || (q[ACC_W-1:31] == '1);
  always_comb begin
    if (ftag.err)   sat = '0;
    else if (fits)  sat = q[31:0];
    else if (q[ACC_W-1]) sat = 32'h8000_0000;
    else            sat = 32'h7fff_ffff;
  end

  logic [mas_pkg::IDX_W-1:0] o_row_r, o_col_r;
  logic [mas_pkg::VAL_W-1:0] o_val_r;
  logic                      o_err_r, o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= ftag.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_row_r  <= ftag.row;
      o_col_r  <= ftag.col;
      o_val_r  <= sat;
      o_err_r  <= ftag.err;
      o_last_r <= ftag.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_val_r, o_col_r, o_row_r};
  assign out_tuser  = o_err_r;
  assign out_tlast  = o_last_r;

  // checks
  a_cnt_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result held with no transaction counted");

  a_comp_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op == mas_pkg::OP_COMPUTE |=> st_r == ST_COMP)
    else $error("compute transaction did not start the sequencer");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("error result not marked last");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIM * MAX_DIM))
    else $error("in-flight count overflow");

endmodule
